// ===== sv/dlsw_pkg.sv =====
// Shared types, constants and segment code functions for the decimal LCD segment writer.
package dlsw_pkg;

  localparam int NUM_POSITIONS = 6;
  localparam int IMAGE_BYTES   = 20;
  localparam int POS_W         = 3;
  localparam int OFF_W         = 5;
  localparam int VALUE_W       = 31;
  localparam int QUOT_W        = 28;

  localparam logic [OFF_W-1:0] NIBBLE_STRIDE = 5'd5;
  localparam logic [15:0]      SPECIAL_CODE  = 16'hC028;
  localparam logic [7:0]       CHAR_ZERO     = 8'h30;
  localparam logic [7:0]       CHAR_NINE     = 8'h39;
  // Reciprocal of ten: n / 10 == (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
  localparam logic [31:0]      RECIP_TEN     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT   = 35;

  typedef struct packed {
    logic                func;
    logic [VALUE_W-1:0]  number_value;
    logic [7:0]          char_code;
    logic [POS_W-1:0]    position;
  } in_word_t;

  typedef struct packed {
    logic [OFF_W-1:0] reg_offset;
    logic [7:0]       reg_data;
    logic             last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_DIGIT,
    ST_WRITE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted input word
    logic mul;    // form value times reciprocal of ten
    logic digit;  // split off quotient and digit, look up its code
    logic wr;     // write one nibble and emit the byte
    logic last;   // the emitted byte ends this item
    logic next;   // step to the next digit position
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic func;
    logic value_zero;
    logic pos_ok;
    logic k_done;
    logic more;
    logic out_free;
  } status_t;

  function automatic logic [15:0] digit_seg(input logic [3:0] d);
    logic [15:0] c;
    case (d)
      4'd0:    c = 16'h1551;
      4'd1:    c = 16'h0110;
      4'd2:    c = 16'h1E11;
      4'd3:    c = 16'h1B11;
      4'd4:    c = 16'h0B50;
      4'd5:    c = 16'h1B41;
      4'd6:    c = 16'h1F41;
      4'd7:    c = 16'h0111;
      4'd8:    c = 16'h1F51;
      4'd9:    c = 16'h0B51;
      default: c = SPECIAL_CODE;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] char_seg(input logic [7:0] ch);
    logic [7:0]  d;
    logic [15:0] c;
    d = ch - CHAR_ZERO;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      c = digit_seg(d[3:0]);
    end else begin
      c = SPECIAL_CODE;
    end
    return c;
  endfunction

endpackage

// ===== sv/decimal_lcd_segment_writer_top.sv =====
// Top level of the decimal LCD segment writer.
// Keeps a 20-byte image of the LCD segment registers (cleared by reset) and emits one
// register write word per written byte, carrying the byte offset from the LCD base and
// the new full byte value; last marks the final word of an input word. A character word
// writes four bytes when its position is below six and nothing otherwise; it is taken
// in ST_IDLE, decoded in ST_DISPATCH, then its four writes leave one per cycle while
// the output word is taken. A number word is taken and decoded the same way, then for
// each shown digit it does the multiply by the reciprocal of ten (ST_MUL), splits off
// quotient and digit (ST_DIGIT) and does four nibble writes (ST_WRITE); the value zero
// shows no digit. The write sequencer stalls when the output word is not taken; a new
// input word is accepted once the previous word's writes are issued.
module decimal_lcd_segment_writer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlsw_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlsw_pkg::out_word_t out_data
);
  import dlsw_pkg::*;

  cmd_t    cmd;
  status_t sts;

  dlsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlsw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/dlsw_ctrl.sv =====
// Controller state machine that sequences digit splitting and byte writes.
module dlsw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dlsw_pkg::status_t sts,
  output dlsw_pkg::cmd_t    cmd
);
  import dlsw_pkg::*;

  state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.func) begin
          state_nxt = sts.pos_ok ? ST_WRITE : ST_IDLE;
        end else begin
          state_nxt = sts.value_zero ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.digit = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.wr = 1'b1;
          if (sts.k_done) begin
            if (sts.func || !sts.more) begin
              cmd.last  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              cmd.next  = 1'b1;
              state_nxt = ST_MUL;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dlsw_datapath.sv =====
// Datapath: segment image, divide-by-ten step, nibble merge and output register.
module dlsw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  dlsw_pkg::in_word_t  in_data,
  input  dlsw_pkg::cmd_t      cmd,
  output dlsw_pkg::status_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output dlsw_pkg::out_word_t out_data
);
  import dlsw_pkg::*;

  logic [7:0]          image_r [IMAGE_BYTES];
  logic                func_r;
  logic [VALUE_W-1:0]  value_r;
  logic [POS_W-1:0]    pos_r;
  logic [15:0]         code_r;
  logic [1:0]          k_r;
  logic [62:0]         prod_r;
  logic [QUOT_W-1:0]   quot_r;
  logic                out_valid_r;
  out_word_t           out_r;

  logic [QUOT_W-1:0]   quot;
  logic [VALUE_W-1:0]  quot_x10;
  logic [VALUE_W-1:0]  rem_full;
  logic [OFF_W-1:0]    offset;
  logic [3:0]          nib;
  logic [7:0]          old_byte;
  logic [7:0]          new_byte;

  // Quotient and remainder of the current value by ten
  assign quot     = prod_r[RECIP_SHIFT +: QUOT_W];
  assign quot_x10 = (VALUE_W'(quot) << 3) + (VALUE_W'(quot) << 1);
  assign rem_full = value_r - quot_x10;

  // Byte offset and nibble for the current write
  assign offset = OFF_W'(pos_r[POS_W-1:1]) + OFF_W'(OFF_W'(k_r) * NIBBLE_STRIDE);
  always_comb begin
    case (k_r)
      2'd0:    nib = code_r[3:0];
      2'd1:    nib = code_r[7:4];
      2'd2:    nib = code_r[11:8];
      default: nib = code_r[15:12];
    endcase
  end
  assign old_byte = image_r[offset];
  assign new_byte = pos_r[0] ? {nib, old_byte[3:0]} : {old_byte[7:4], nib};

  // Capture the item and step through digits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_data.func;
      value_r <= in_data.number_value;
      pos_r   <= in_data.func ? in_data.position : POS_W'(NUM_POSITIONS - 1);
      code_r  <= char_seg(in_data.char_code);
    end else if (cmd.next) begin
      value_r <= VALUE_W'(quot_r);
      pos_r   <= pos_r - POS_W'(1);
    end else if (cmd.digit) begin
      code_r  <= digit_seg(rem_full[3:0]);
    end
    if (cmd.mul) begin
      prod_r <= 63'(value_r) * 63'(RECIP_TEN);
    end
    if (cmd.digit) begin
      quot_r <= quot;
    end
  end

  // Advance the nibble counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.load) begin
      k_r <= '0;
    end else if (cmd.wr) begin
      k_r <= k_r + 2'd1;
    end
  end

  // Update the segment image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IMAGE_BYTES; i++) begin
        image_r[i] <= '0;
      end
    end else if (cmd.wr) begin
      image_r[offset] <= new_byte;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_r.reg_offset <= offset;
      out_r.reg_data   <= new_byte;
      out_r.last       <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Report status
  assign sts.func       = func_r;
  assign sts.value_zero = (value_r == '0);
  assign sts.pos_ok     = (pos_r < POS_W'(NUM_POSITIONS));
  assign sts.k_done     = (k_r == 2'd3);
  assign sts.more       = (quot_r != '0) && (pos_r != '0);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the decimal LCD segment writer: drives character and number words, checks each register write.
`timescale 1ns / 100ps

module tb_top;
  import dlsw_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Local copy of the segment register image and the writes it still owes
  logic [7:0] lcd_image [IMAGE_BYTES];
  out_word_t  pending_writes [$];
  int         mismatch_count;
  bit         steady_flow;
  out_word_t  want;

  decimal_lcd_segment_writer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Generous run limit
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Segment code of one decimal digit
  function automatic logic [15:0] digit_code(input logic [3:0] d);
    logic [15:0] c;
    case (d)
      4'd0:    c = 16'h1551;
      4'd1:    c = 16'h0110;
      4'd2:    c = 16'h1E11;
      4'd3:    c = 16'h1B11;
      4'd4:    c = 16'h0B50;
      4'd5:    c = 16'h1B41;
      4'd6:    c = 16'h1F41;
      4'd7:    c = 16'h0111;
      4'd8:    c = 16'h1F51;
      default: c = 16'h0B51;
    endcase
    return c;
  endfunction

  // Update one cell's four nibbles and queue the resulting byte writes
  task automatic write_cell(input logic [7:0] ch, input int unsigned pos);
    logic [15:0] code;
    int unsigned off;
    out_word_t   w;
    if (pos >= NUM_POSITIONS) return;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) code = digit_code(4'(ch - CHAR_ZERO));
    else code = SPECIAL_CODE;
    for (int k = 0; k < 4; k++) begin
      off = pos / 2 + NIBBLE_STRIDE * k;
      if (pos % 2 == 1) lcd_image[off][7:4] = code[4*k +: 4];
      else lcd_image[off][3:0] = code[4*k +: 4];
      w.reg_offset = off[OFF_W-1:0];
      w.reg_data   = lcd_image[off];
      w.last       = 1'b0;
      pending_writes.push_back(w);
    end
  endtask

  // Work out every register write an accepted word causes
  task automatic predict_lcd_writes(input in_word_t w);
    int          depth_before;
    int unsigned v;
    out_word_t   tail;
    depth_before = pending_writes.size();
    if (w.func) begin
      write_cell(w.char_code, 32'(w.position));
    end else begin
      v = 32'(w.number_value);
      // least significant digit goes to the rightmost cell; stop once nothing is left
      for (int p = NUM_POSITIONS - 1; p >= 0 && v != 0; p--) begin
        write_cell(CHAR_ZERO + 8'(v % 10), p);
        v = v / 10;
      end
    end
    if (pending_writes.size() > depth_before) begin
      tail = pending_writes.pop_back();
      tail.last = 1'b1;
      pending_writes.push_back(tail);
    end
  endtask

  // Send one word; sometimes idle first
  task automatic send_word(input in_word_t w);
    int gap;
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    predict_lcd_writes(w);
  endtask

  // Drop valid and hold off until every owed write has come out
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t char_word(input logic [7:0] ch, input logic [2:0] pos);
    in_word_t w;
    w.func         = 1'b1;
    w.number_value = VALUE_W'($urandom);
    w.char_code    = ch;
    w.position     = pos;
    return w;
  endfunction

  function automatic in_word_t number_word(input int unsigned value);
    in_word_t w;
    w.func         = 1'b0;
    w.number_value = value[VALUE_W-1:0];
    w.char_code    = 8'($urandom);
    w.position     = 3'($urandom);
    return w;
  endfunction

  function automatic in_word_t random_char_word();
    logic [7:0] ch;
    if ($urandom_range(0, 1) == 0) ch = CHAR_ZERO + 8'($urandom_range(0, 9));
    else ch = 8'($urandom);
    return char_word(ch, 3'($urandom_range(0, 7)));
  endfunction

  function automatic in_word_t random_number_word();
    int unsigned v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(0, 999);
      2: v = $urandom_range(0, 999999);
      3: begin
        // trailing zeros, sometimes beyond six digits
        v = $urandom_range(1, 9);
        repeat ($urandom_range(1, 8)) v = v * 10;
      end
      default: v = $urandom & 32'h7FFF_FFFF;
    endcase
    return number_word(v);
  endfunction

  function automatic in_word_t random_word();
    if ($urandom_range(0, 1) == 0) return random_char_word();
    return random_number_word();
  endfunction

  // Directed: every digit, special symbols, both nibble halves, out of range cells, number edges
  task automatic test_directed();
    send_word(char_word(8'h30, 3'd0));
    send_word(char_word(8'h39, 3'd1));
    send_word(char_word(8'h35, 3'd2));
    send_word(char_word(8'h33, 3'd3));
    send_word(char_word(8'h38, 3'd4));
    send_word(char_word(8'h31, 3'd5));
    send_word(char_word(8'h00, 3'd0));
    send_word(char_word(8'hFF, 3'd5));
    send_word(char_word(8'h2F, 3'd2));
    send_word(char_word(8'h3A, 3'd3));
    send_word(char_word(8'h37, 3'd6));
    send_word(char_word(8'h41, 3'd7));
    send_word(char_word(8'h32, 3'd4));
    send_word(char_word(8'h34, 3'd1));
    send_word(char_word(8'h36, 3'd0));
    send_word(char_word(8'h37, 3'd2));
    send_word(number_word(0));
    send_word(number_word(1));
    send_word(number_word(10));
    send_word(number_word(123));
    send_word(number_word(999999));
    send_word(number_word(1000000));
    send_word(number_word(32'h7FFF_FFFF));
    send_word(number_word(100));
  endtask

  task automatic test_random_chars();
    repeat (140) send_word(random_char_word());
  endtask

  task automatic test_random_numbers();
    repeat (140) send_word(random_number_word());
  endtask

  task automatic test_mixed();
    repeat (100) send_word(random_word());
  endtask

  // Last part: no idling on either side
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (60) send_word(random_word());
  endtask

  // Receiver: ready stretches with random stall bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!steady_flow && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // Compare each accepted write word with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write word: reg_offset %0d reg_data 0x%02h last %0b",
               out_data.reg_offset, out_data.reg_data, out_data.last);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_data.reg_offset !== want.reg_offset) begin
          $error("reg_offset mismatch: expected %0d, actual %0d",
                 want.reg_offset, out_data.reg_offset);
          mismatch_count++;
        end
        if (out_data.reg_data !== want.reg_data) begin
          $error("reg_data mismatch: expected 0x%02h, actual 0x%02h",
                 want.reg_data, out_data.reg_data);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    steady_flow    = 1'b0;
    for (int i = 0; i < IMAGE_BYTES; i++) lcd_image[i] = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_drain();
    test_random_chars();
    test_random_numbers();
    test_mixed();
    test_back_to_back();

    wait_drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
